### rtl/sfmer_pkg.sv
package sfmer_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int RUN_W      = 7;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_MARK   = 2'd1;
    localparam logic [1:0] ACT_REPORT = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] from_slot;
        logic [7:0] to_slot;
        logic       mark_free;
    } t_in;

    typedef struct packed {
        logic [RUN_W-1:0] run_start;
        logic [RUN_W-1:0] run_length;
        logic             last_run;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic mark;
        logic start;
        logic step;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic stall;
        logic at_last;
        logic out_free;
    } t_stat;

endpackage

### rtl/slot_free_map_with_extent_report_top.sv
// Free/used map of 64 slots (numbered 1..64) with a run report. A clear or
// mark-range transaction updates the map when accepted and returns nothing;
// a mark applies to from_slot..to_slot clamped to 1..64, and a reversed
// range changes nothing. A report walks the map one slot per cycle, unless
// the result side stalls the scan, and returns one transaction per maximal
// free run, the last one flagged with last_run; with no free slot it
// returns a single (0, 0, last) result. The input is not taken during a
// report's start, its 64 scan steps and its wrap-up. The result sits in
// an output register, so update transactions are taken while it waits.
module slot_free_map_with_extent_report_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sfmer_pkg::t_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output sfmer_pkg::t_out o_out_data
);
    import sfmer_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sfmer_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_in_data.action),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sfmer_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/sfmer_ctrl.sv
module sfmer_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_action,
    input  sfmer_pkg::t_stat i_stat,
    output sfmer_pkg::t_cmd  o_cmd
);
    import sfmer_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.clear = (i_action == ACT_CLEAR);
                    o_cmd.mark  = (i_action == ACT_MARK);
                    o_cmd.start = (i_action == ACT_REPORT);
                    if (i_action == ACT_REPORT) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // hold the scan while a finished run cannot move out
                if (!i_stat.stall) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.at_last) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/sfmer_dp.sv
module sfmer_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfmer_pkg::t_cmd  i_cmd,
    input  sfmer_pkg::t_in   i_in_data,
    output sfmer_pkg::t_stat o_stat,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output sfmer_pkg::t_out  o_out_data
);
    import sfmer_pkg::*;

    logic [SLOT_COUNT-1:0] r_free_bits;
    logic [SLOT_COUNT-1:0] mask;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_in_run;
    logic [RUN_W-1:0]      r_run_start;
    logic [RUN_W-1:0]      r_run_len;
    logic                  r_pend_valid;
    logic [RUN_W-1:0]      r_pend_start;
    logic [RUN_W-1:0]      r_pend_len;
    logic                  r_out_valid;
    t_out                  r_out;

    logic                  bit_free;
    logic                  at_last;
    logic                  run_done;
    logic [RUN_W-1:0]      slot_num;
    logic [RUN_W-1:0]      done_start;
    logic [RUN_W-1:0]      done_len;
    logic                  out_free;
    logic                  out_load;

    // range mask: slot i+1 lies within from..to; an empty range gives no bits
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            mask[i] = (8'(i + 1) >= i_in_data.from_slot)
                   && (8'(i + 1) <= i_in_data.to_slot);
        end
    end

    assign bit_free = r_free_bits[r_idx];
    assign at_last  = (r_idx == IDX_W'(SLOT_COUNT - 1));
    assign slot_num = RUN_W'(r_idx) + RUN_W'(1);
    assign out_free = !r_out_valid || i_out_ready;

    // a run closes on the first used slot after it, or at the last slot
    always_comb begin
        run_done   = 1'b0;
        done_start = r_run_start;
        done_len   = r_run_len;
        if (!bit_free) begin
            run_done = r_in_run;
        end else if (at_last) begin
            run_done   = 1'b1;
            done_start = r_in_run ? r_run_start : slot_num;
            done_len   = r_in_run ? (r_run_len + RUN_W'(1)) : RUN_W'(1);
        end
    end

    assign out_load = i_cmd.finish || (i_cmd.step && run_done && r_pend_valid);

    assign o_stat.stall    = run_done && r_pend_valid && !out_free;
    assign o_stat.at_last  = at_last;
    assign o_stat.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_bits  <= '0;
            r_in_run     <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_free_bits <= '0;
            end
            if (i_cmd.mark) begin
                if (i_in_data.mark_free) begin
                    r_free_bits <= r_free_bits | mask;
                end else begin
                    r_free_bits <= r_free_bits & ~mask;
                end
            end
            if (i_cmd.start) begin
                r_idx        <= '0;
                r_in_run     <= 1'b0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.step) begin
                r_idx <= r_idx + IDX_W'(1);
                if (bit_free) begin
                    if (!r_in_run) begin
                        r_run_start <= slot_num;
                        r_run_len   <= RUN_W'(1);
                    end else begin
                        r_run_len <= r_run_len + RUN_W'(1);
                    end
                end
                r_in_run <= bit_free;
                if (run_done) begin
                    // the pending run is not the last one: send it on
                    if (r_pend_valid) begin
                        r_out <= '{run_start: r_pend_start,
                                   run_length: r_pend_len,
                                   last_run: 1'b0};
                    end
                    r_pend_valid <= 1'b1;
                    r_pend_start <= done_start;
                    r_pend_len   <= done_len;
                end
            end
            if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
                if (r_pend_valid) begin
                    r_out <= '{run_start: r_pend_start, run_length: r_pend_len,
                               last_run: 1'b1};
                end else begin
                    r_out <= '{run_start: '0, run_length: '0, last_run: 1'b1};
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/sfmer_chk.sv
module sfmer_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input sfmer_pkg::t_in  i_in_data,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input sfmer_pkg::t_out o_out_data
);
    import sfmer_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_report_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.action == ACT_REPORT |=> !o_in_ready)
        else $error("input taken during report scan");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.run_length == '0 |->
            o_out_data.run_start == '0 && o_out_data.last_run)
        else $error("empty result not flagged last");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.run_length != '0 |->
            o_out_data.run_start != '0)
        else $error("run starts at slot zero");

    a_run_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (8'(o_out_data.run_start) + 8'(o_out_data.run_length))
                <= 8'(SLOT_COUNT + 1))
        else $error("run extends past last slot");

endmodule

bind slot_free_map_with_extent_report_top sfmer_chk u_sfmer_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### tb/slot_free_map_with_extent_report_checker.sv
module slot_free_map_with_extent_report_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  sfmer_pkg::t_in  i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  sfmer_pkg::t_out i_out_data,
    output int              o_errors,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfmer_pkg::*;

    localparam int MAX_RUNS = (SLOT_COUNT + 1) / 2;

    logic [SLOT_COUNT-1:0] free_map;
    t_out                  expected_runs[$];
    bit                    cmd_seen;

    task automatic report_error(string msg);
        $display("[%0t] checker: %s", $time, msg);
        o_errors++;
    endtask

    function automatic void mark_slots(t_in cmd);
        int lo;
        int hi;
        if (cmd.from_slot > cmd.to_slot)
            return;
        hi = (cmd.to_slot > SLOT_COUNT) ? SLOT_COUNT : int'(cmd.to_slot);
        lo = (cmd.from_slot < 1) ? 1 : int'(cmd.from_slot);
        for (int s = lo; s <= hi; s++)
            free_map[s-1] = cmd.mark_free;
    endfunction

    function automatic void list_free_runs();
        t_out runs[MAX_RUNS];
        int   n;
        int   s;
        int   first;
        int   len;
        n = 0;
        s = 1;
        while (s <= SLOT_COUNT) begin
            if (free_map[s-1]) begin
                first = s;
                len   = 0;
                while (s <= SLOT_COUNT && free_map[s-1]) begin
                    len++;
                    s++;
                end
                if (n < MAX_RUNS) begin
                    runs[n].run_start  = RUN_W'(first);
                    runs[n].run_length = RUN_W'(len);
                    runs[n].last_run   = 1'b0;
                    n++;
                end
            end
            s++;
        end
        if (n == 0) begin
            runs[0] = '{run_start: '0, run_length: '0, last_run: 1'b1};
            n = 1;
        end
        runs[n-1].last_run = 1'b1;
        for (int i = 0; i < n; i++)
            expected_runs.push_back(runs[i]);
    endfunction

    function automatic void predict_cmd(t_in cmd);
        case (cmd.action)
            ACT_CLEAR:  free_map = '0;
            ACT_MARK:   mark_slots(cmd);
            ACT_REPORT: list_free_runs();
            default:    ;
        endcase
    endfunction

    task automatic check_run(t_out got);
        t_out want;
        if (expected_runs.size() == 0) begin
            report_error($sformatf("unexpected result start %0d length %0d last %0d",
                                   got.run_start, got.run_length, got.last_run));
            return;
        end
        want = expected_runs.pop_front();
        if (got.run_start !== want.run_start)
            report_error($sformatf("run_start got %0d want %0d",
                                   got.run_start, want.run_start));
        if (got.run_length !== want.run_length)
            report_error($sformatf("run_length got %0d want %0d (start %0d)",
                                   got.run_length, want.run_length, want.run_start));
        if (got.last_run !== want.last_run)
            report_error($sformatf("last_run got %0d want %0d (start %0d)",
                                   got.last_run, want.last_run, want.run_start));
    endtask

    // Predict on first sight of a transaction: the payload holds until it
    // is accepted, so the order matches the order of acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            free_map = '0;
            expected_runs.delete();
            cmd_seen = 1'b0;
        end else begin
            if (i_in_valid && !cmd_seen) begin
                predict_cmd(i_in_data);
                cmd_seen = 1'b1;
            end
            if (i_in_valid && i_in_ready)
                cmd_seen = 1'b0;
            if (i_out_valid && i_out_ready)
                check_run(i_out_data);
        end
        o_pending = expected_runs.size();
    end

endmodule

### tb/slot_free_map_with_extent_report_top_test.sv
module slot_free_map_with_extent_report_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sfmer_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         ITEM_TARGET  = 460;
    localparam int         SETTLE_TICKS = 80;
    localparam int         MAX_GAP      = 16;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;

    int failures;
    int pending;
    bit no_gaps    = 1'b0;
    int sent_items = 0;
    int gap_left   = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    slot_free_map_with_extent_report_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    slot_free_map_with_extent_report_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_errors    (failures),
        .o_pending   (pending)
    );

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic t_in make_cmd(logic [1:0] act, int from, int to, bit free);
        t_in cmd;
        cmd.action    = act;
        cmd.from_slot = 8'(from);
        cmd.to_slot   = 8'(to);
        cmd.mark_free = free;
        return cmd;
    endfunction

    task automatic send(t_in cmd);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = cmd;
        do @(posedge clk); while (!in_ready);
        if (cmd.action != ACT_UNUSED)
            sent_items++;
    endtask

    task automatic mark(int from, int to, bit free);
        send(make_cmd(ACT_MARK, from, to, free));
    endtask

    // Clear and report ignore the range fields; fill them with noise.
    task automatic send_plain(logic [1:0] act);
        send(make_cmd(act, $urandom_range(0, 255), $urandom_range(0, 255),
                      1'($urandom_range(0, 1))));
    endtask

    task automatic random_mark();
        int from;
        int to;
        case ($urandom_range(0, 9))
            0: begin
                from = $urandom_range(0, 255);
                to   = $urandom_range(0, 255);
            end
            1: begin
                from = $urandom_range(0, SLOT_COUNT);
                to   = $urandom_range(SLOT_COUNT, 255);
            end
            default: begin
                from = $urandom_range(0, SLOT_COUNT + 2);
                to   = from + $urandom_range(0, 12);
            end
        endcase
        mark(from, to, 1'($urandom_range(0, 1)));
    endtask

    // Free everything, then knock out every stride-th slot.
    task automatic comb_pattern();
        int stride;
        int phase;
        stride = ($urandom_range(0, 1) == 0) ? 2 : $urandom_range(2, 4);
        phase  = $urandom_range(1, stride);
        mark(0, 255, 1'b1);
        for (int s = phase; s <= SLOT_COUNT; s += stride)
            mark(s, s, 1'b0);
        send_plain(ACT_REPORT);
    endtask

    // Hold off new commands until every expected result has come back.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        out_ready = 1'b0;
        gap_left  = draw_gap();
        forever begin
            @(negedge clk);
            if (gap_left > 0) begin
                out_ready = 1'b0;
                gap_left--;
            end else begin
                out_ready = 1'b1;
            end
            @(posedge clk);
            if (out_ready && out_valid)
                gap_left = draw_gap();
        end
    end

    initial begin
        in_valid = 1'b0;
        in_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty map, ranges that change nothing
        send_plain(ACT_REPORT);
        mark(0, 0, 1'b1);
        mark(200, 100, 1'b1);
        mark(SLOT_COUNT + 1, 255, 1'b1);
        mark(255, 255, 1'b1);
        send_plain(ACT_REPORT);
        // first and last slot
        mark(SLOT_COUNT, SLOT_COUNT, 1'b1);
        mark(1, 1, 1'b1);
        send_plain(ACT_REPORT);
        // whole map through clamping, then holes
        mark(0, 255, 1'b1);
        send_plain(ACT_REPORT);
        mark(10, 20, 1'b0);
        mark(60, 255, 1'b0);
        send_plain(ACT_REPORT);
        send(make_cmd(ACT_UNUSED, 255, 0, 1'b1));
        send(make_cmd(ACT_CLEAR, 255, 255, 1'b1));
        send_plain(ACT_REPORT);
        mark(0, SLOT_COUNT - 1, 1'b1);
        send_plain(ACT_REPORT);
        mark(0, 255, 1'b0);
        send_plain(ACT_REPORT);
        drain();

        while (sent_items < ITEM_TARGET) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 19))
                0: comb_pattern();
                1, 2, 3: begin
                    repeat ($urandom_range(1, 4))
                        send(make_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                                      $urandom_range(0, 255),
                                      1'($urandom_range(0, 1))));
                end
                4: send_plain(ACT_REPORT);
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        send_plain(ACT_CLEAR);
                    repeat ($urandom_range(1, 6)) random_mark();
                    send_plain(ACT_REPORT);
                end
            endcase
            if ($urandom_range(0, 9) == 0)
                drain();
        end

        drain();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
